// ===== rtl/core/e2e11_pkg.sv =====
// shared types, constants and helper functions for the e2e profile 11 block
`default_nettype none

package e2e11_pkg;

    localparam int MAX_FRAME_BYTES = 8;
    localparam int COUNTER_MAX     = 14;
    localparam int FRAME_W         = 8 * MAX_FRAME_BYTES;

    localparam logic [7:0] CRC_POLY  = 8'h1D;
    localparam logic [7:0] CRC_INIT  = 8'hFF;
    localparam logic [7:0] CRC_XOROUT = 8'hFF;

    typedef enum logic [2:0] {
        REG_ROLE     = 3'd0,
        REG_DATA_ID  = 3'd1,
        REG_ID_MODE  = 3'd2,
        REG_FRAME_BYTES = 3'd3,
        REG_CNT_OFF  = 3'd4,
        REG_CRC_IDX  = 3'd5,
        REG_NIB_OFF  = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        ID_BOTH   = 2'd0,
        ID_NIBBLE = 2'd1,
        ID_NONE   = 2'd2
    } id_mode_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_LOST         = 3'd1,
        ST_REPEATED     = 3'd2,
        ST_ERROR        = 3'd3,
        ST_WRONG_INPUT  = 3'd4,
        ST_CONFIG_FAULT = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        KIND_RUN   = 2'd0,
        KIND_WRONG = 2'd1,
        KIND_FAULT = 2'd2
    } kind_t;

    typedef enum logic {
        ROLE_PROTECT = 1'b0,
        ROLE_CHECK   = 1'b1
    } role_t;

    typedef struct packed {
        logic        role;
        logic [15:0] data_id;
        logic [1:0]  id_mode;
        logic [3:0]  frame_bytes;
        logic [5:0]  cnt_off;
        logic [2:0]  crc_idx;
        logic [5:0]  nib_off;
    } cfg_t;

    typedef struct packed {
        kind_t               kind;
        logic [FRAME_W-1:0]  frame;
        logic [3:0]          len;
        logic                nib_err;
        logic [7:0]          crc_seed;
    } req_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame;
        status_t             status;
    } res_t;

    typedef struct packed {
        logic load;
        logic role;
    } ctr_load_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [3:0] read_nib(input logic [FRAME_W-1:0] frame,
                                            input logic [5:0] pos);
        logic [7:0] b;
        b = frame[{pos[5:3], 3'b000} +: 8];
        b = b >> pos[2:0];
        return b[3:0];
    endfunction

    function automatic logic [FRAME_W-1:0] write_nib(input logic [FRAME_W-1:0] frame,
                                                     input logic [5:0] pos,
                                                     input logic [3:0] val);
        logic [FRAME_W-1:0] f;
        logic [7:0]         b;
        logic [11:0]        m;
        logic [11:0]        v;
        f = frame;
        b = f[{pos[5:3], 3'b000} +: 8];
        m = 12'h00F << pos[2:0];
        v = {8'h00, val} << pos[2:0];
        b = (b & ~m[7:0]) | v[7:0];
        f[{pos[5:3], 3'b000} +: 8] = b;
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/e2e11_front.sv =====
// front part: length and offset classification, nibble insertion or check and crc seed
`default_nettype none

module e2e11_front (
    input  wire e2e11_pkg::cfg_t                   cfg,
    input  wire logic [e2e11_pkg::FRAME_W-1:0]     frame_data,
    input  wire logic [3:0]                        frame_len,
    output e2e11_pkg::req_t                        req
);

    logic       wrong;
    logic       fault;
    logic [7:0] seed;

    always_comb
    begin
        wrong = (frame_len != cfg.frame_bytes) ||
                (frame_len > 4'(e2e11_pkg::MAX_FRAME_BYTES));

        fault = ((cfg.id_mode == e2e11_pkg::ID_NIBBLE) &&
                 ({1'b0, cfg.nib_off[5:3]} >= frame_len)) ||
                ({1'b0, cfg.cnt_off[5:3]} >= frame_len) ||
                ({1'b0, cfg.crc_idx} >= frame_len) ||
                ((cfg.role == e2e11_pkg::ROLE_PROTECT) && (cfg.cnt_off[2:0] > 3'd4));

        // crc over the data id bytes only depends on configuration
        seed = e2e11_pkg::CRC_INIT;
        case (cfg.id_mode)
            e2e11_pkg::ID_BOTH:
            begin
                seed = e2e11_pkg::crc8_byte(seed, cfg.data_id[7:0]);
                seed = e2e11_pkg::crc8_byte(seed, cfg.data_id[15:8]);
            end
            e2e11_pkg::ID_NIBBLE:
            begin
                seed = e2e11_pkg::crc8_byte(seed, cfg.data_id[7:0]);
                seed = e2e11_pkg::crc8_byte(seed, 8'h00);
            end
            default:
            begin
                seed = e2e11_pkg::CRC_INIT;
            end
        endcase

        if (wrong)
        begin
            req.kind = e2e11_pkg::KIND_WRONG;
        end
        else if (fault)
        begin
            req.kind = e2e11_pkg::KIND_FAULT;
        end
        else
        begin
            req.kind = e2e11_pkg::KIND_RUN;
        end

        req.len      = frame_len;
        req.crc_seed = seed;
        req.nib_err  = (cfg.role == e2e11_pkg::ROLE_CHECK) &&
                       (cfg.id_mode == e2e11_pkg::ID_NIBBLE) &&
                       (e2e11_pkg::read_nib(frame_data, cfg.nib_off) != cfg.data_id[11:8]);

        if ((cfg.role == e2e11_pkg::ROLE_PROTECT) && (cfg.id_mode == e2e11_pkg::ID_NIBBLE))
        begin
            req.frame = e2e11_pkg::write_nib(frame_data, cfg.nib_off, cfg.data_id[11:8]);
        end
        else
        begin
            req.frame = frame_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/e2e11_queue.sv =====
// two-entry queue of classified requests between front and back
`default_nettype none

module e2e11_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire e2e11_pkg::req_t push_req,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output e2e11_pkg::req_t      head_req
);

    e2e11_pkg::req_t entries_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            do_push;
    logic            do_pop;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        head_valid  = (count_reg != 2'd0);
        head_req    = entries_reg[rd_ptr_reg];
        do_push     = push && !full;
        do_pop      = pop && head_valid;
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/e2e11_back.sv =====
// back part: counter insertion, crc, status, sequence counter and result queue
`default_nettype none

module e2e11_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire e2e11_pkg::cfg_t               cfg,
    input  wire e2e11_pkg::ctr_load_t          ctr_load,
    input  wire logic                          req_valid,
    input  wire e2e11_pkg::req_t               req,
    output logic                               req_pop,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [e2e11_pkg::FRAME_W-1:0]      frame_out,
    output logic [2:0]                         status
);

    localparam int NB = e2e11_pkg::MAX_FRAME_BYTES;

    logic [3:0]                    seq_reg;
    logic [3:0]                    seq_next;
    e2e11_pkg::res_t               res_reg [2];
    logic                          wr_ptr_reg;
    logic                          wr_ptr_next;
    logic                          rd_ptr_reg;
    logic                          rd_ptr_next;
    logic [1:0]                    count_reg;
    logic [1:0]                    count_next;

    e2e11_pkg::res_t               res;
    logic [e2e11_pkg::FRAME_W-1:0] work;
    logic [7:0]                    crc;
    logic [3:0]                    rc;
    logic [4:0]                    delta;
    logic                          fire;
    logic                          do_pop;

    always_comb
    begin
        fire   = req_valid && (count_reg != 2'd2);
        req_pop = fire;
        empty  = (count_reg == 2'd0);
        do_pop = pop && !empty;

        rc = e2e11_pkg::read_nib(req.frame, cfg.cnt_off);
        if (cfg.role == e2e11_pkg::ROLE_PROTECT)
        begin
            work = e2e11_pkg::write_nib(req.frame, cfg.cnt_off, seq_reg);
        end
        else
        begin
            work = req.frame;
        end

        crc = req.crc_seed;
        for (int i = 0; i < NB; i++)
        begin
            if ((4'(i) < req.len) && (3'(i) != cfg.crc_idx))
            begin
                crc = e2e11_pkg::crc8_byte(crc, work[8*i +: 8]);
            end
        end
        crc = crc ^ e2e11_pkg::CRC_XOROUT;

        if (rc >= seq_reg)
        begin
            delta = {1'b0, rc} - {1'b0, seq_reg};
        end
        else
        begin
            delta = {1'b0, rc} + 5'(e2e11_pkg::COUNTER_MAX) + 5'd1 - {1'b0, seq_reg};
        end

        res.frame  = '0;
        res.status = e2e11_pkg::ST_OK;
        seq_next   = seq_reg;

        case (req.kind)
            e2e11_pkg::KIND_WRONG:
            begin
                res.status = e2e11_pkg::ST_WRONG_INPUT;
            end
            e2e11_pkg::KIND_FAULT:
            begin
                res.status = e2e11_pkg::ST_CONFIG_FAULT;
            end
            e2e11_pkg::KIND_RUN:
            begin
                if (cfg.role == e2e11_pkg::ROLE_PROTECT)
                begin
                    for (int i = 0; i < NB; i++)
                    begin
                        if (4'(i) < req.len)
                        begin
                            res.frame[8*i +: 8] = (3'(i) == cfg.crc_idx) ? crc
                                                                         : work[8*i +: 8];
                        end
                    end
                    seq_next = (seq_reg == 4'(e2e11_pkg::COUNTER_MAX)) ? 4'd0
                                                                         : seq_reg + 4'd1;
                end
                else if ((crc != work[{cfg.crc_idx, 3'b000} +: 8]) || req.nib_err)
                begin
                    res.status = e2e11_pkg::ST_ERROR;
                end
                else
                begin
                    seq_next = rc;
                    if (delta == 5'd0)
                    begin
                        res.status = e2e11_pkg::ST_REPEATED;
                    end
                    else if (delta == 5'd1)
                    begin
                        res.status = e2e11_pkg::ST_OK;
                    end
                    else
                    begin
                        res.status = e2e11_pkg::ST_LOST;
                    end
                end
            end
            default:
            begin
                res.status = e2e11_pkg::ST_CONFIG_FAULT;
            end
        endcase

        if (!fire)
        begin
            seq_next = seq_reg;
        end
        if (ctr_load.load)
        begin
            seq_next = ctr_load.role ? 4'(e2e11_pkg::COUNTER_MAX) : 4'd0;
        end

        wr_ptr_next = wr_ptr_reg ^ fire;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, fire} - {1'b0, do_pop};

        frame_out = res_reg[rd_ptr_reg].frame;
        status    = res_reg[rd_ptr_reg].status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= 4'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            seq_reg    <= seq_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/e2e_profile11_protect_check.sv =====
// top level of the e2e profile 11 protect and check block
`default_nettype none

// Takes one frame per clock while the request queue is not full and returns
// exactly one result per frame, in order. A request waits in a two-entry
// queue until the back stage takes it, which it does only while its
// two-entry result queue is not full; the result is then registered into
// that result queue. The back stage computes the CRC-8 over the frame bytes
// combinationally, which sets the clock limit of the block. Configuration
// is written through wr_en, wr_index and wr_data; any write to the role
// register reloads the sequence counter (0 for protect, 14 for check).
module e2e_profile11_protect_check (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [2:0]                    wr_index,
    input  wire logic [15:0]                   wr_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [e2e11_pkg::FRAME_W-1:0] frame_data,
    input  wire logic [3:0]                    frame_len,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [e2e11_pkg::FRAME_W-1:0]      frame_out,
    output logic [2:0]                         status
);

    e2e11_pkg::cfg_t      cfg_reg;
    e2e11_pkg::cfg_t      cfg_next;
    e2e11_pkg::ctr_load_t ctr_load;
    e2e11_pkg::req_t      front_req;
    e2e11_pkg::req_t      head_req;
    logic                 head_valid;
    logic                 req_pop;

    always_comb
    begin
        cfg_next      = cfg_reg;
        ctr_load.load = 1'b0;
        ctr_load.role = wr_data[0];
        if (wr_en)
        begin
            case (wr_index)
                e2e11_pkg::REG_ROLE:
                begin
                    cfg_next.role = wr_data[0];
                    ctr_load.load = 1'b1;
                end
                e2e11_pkg::REG_DATA_ID:     cfg_next.data_id     = wr_data;
                e2e11_pkg::REG_ID_MODE:     cfg_next.id_mode     = wr_data[1:0];
                e2e11_pkg::REG_FRAME_BYTES: cfg_next.frame_bytes = wr_data[3:0];
                e2e11_pkg::REG_CNT_OFF:     cfg_next.cnt_off     = wr_data[5:0];
                e2e11_pkg::REG_CRC_IDX:     cfg_next.crc_idx     = wr_data[2:0];
                e2e11_pkg::REG_NIB_OFF:     cfg_next.nib_off     = wr_data[5:0];
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.role        <= 1'b0;
            cfg_reg.data_id     <= 16'h0000;
            cfg_reg.id_mode     <= 2'd0;
            cfg_reg.frame_bytes <= 4'(e2e11_pkg::MAX_FRAME_BYTES);
            cfg_reg.cnt_off     <= 6'd0;
            cfg_reg.crc_idx     <= 3'd0;
            cfg_reg.nib_off     <= 6'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    e2e11_front u_front (
        .cfg        (cfg_reg),
        .frame_data (frame_data),
        .frame_len  (frame_len),
        .req        (front_req)
    );

    e2e11_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_req   (front_req),
        .full       (full),
        .pop        (req_pop),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    e2e11_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctr_load  (ctr_load),
        .req_valid (head_valid),
        .req       (head_req),
        .req_pop   (req_pop),
        .empty     (empty),
        .pop       (pop),
        .frame_out (frame_out),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking testbench for the e2e profile 11 protect and check block
`default_nettype none

module tb_top;
    import e2e11_pkg::*;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        wr_en      = 1'b0;
    logic [2:0]  wr_index   = '0;
    logic [15:0] wr_data    = '0;
    logic        push       = 1'b0;
    logic [63:0] frame_data = '0;
    logic [3:0]  frame_len  = '0;
    logic        pop        = 1'b0;
    logic        full;
    logic        empty;
    logic [63:0] frame_out;
    logic [2:0]  status;

    cfg_t        model_cfg;
    logic [3:0]  model_seq;
    res_t        pending_results[$];
    int          errors       = 0;
    int          sent_count   = 0;
    int          setup_count  = 0;
    int          status_hits[6];
    bit          tx_burst     = 1'b0;
    bit          rx_burst     = 1'b0;

    e2e_profile11_protect_check u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .push       (push),
        .full       (full),
        .frame_data (frame_data),
        .frame_len  (frame_len),
        .empty      (empty),
        .pop        (pop),
        .frame_out  (frame_out),
        .status     (status)
    );

    always #2 clk = ~clk;

    function automatic cfg_t make_cfg(role_t r, logic [15:0] id, logic [1:0] mode,
                                      logic [3:0] fb, logic [5:0] cnt, logic [2:0] crc,
                                      logic [5:0] nib);
        cfg_t c;
        c.role        = r;
        c.data_id     = id;
        c.id_mode     = mode;
        c.frame_bytes = fb;
        c.cnt_off     = cnt;
        c.crc_idx     = crc;
        c.nib_off     = nib;
        return c;
    endfunction

    function automatic logic [7:0] crc_feed(logic [7:0] crc, logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] frame_crc(logic [63:0] f, logic [3:0] len);
        logic [7:0] c;
        c = CRC_INIT;
        if (model_cfg.id_mode == ID_NIBBLE)
        begin
            c = crc_feed(c, model_cfg.data_id[7:0]);
            c = crc_feed(c, 8'h00);
        end
        else if (model_cfg.id_mode == ID_BOTH)
        begin
            c = crc_feed(c, model_cfg.data_id[7:0]);
            c = crc_feed(c, model_cfg.data_id[15:8]);
        end
        for (int i = 0; i < MAX_FRAME_BYTES; i++)
        begin
            if (i < len && i != model_cfg.crc_idx)
                c = crc_feed(c, f[8*i +: 8]);
        end
        return c ^ CRC_XOROUT;
    endfunction

    // nibble access stays inside one byte, upper bits fall off
    function automatic logic [3:0] get_nibble(logic [63:0] f, logic [5:0] pos);
        logic [7:0] b;
        b = f[{pos[5:3], 3'b000} +: 8];
        b = b >> pos[2:0];
        return b[3:0];
    endfunction

    function automatic logic [63:0] put_nibble(logic [63:0] f, logic [5:0] pos,
                                               logic [3:0] v);
        logic [63:0] w;
        logic [7:0]  b;
        logic [7:0]  m;
        logic [7:0]  d;
        w = f;
        b = w[{pos[5:3], 3'b000} +: 8];
        m = 8'h0F << pos[2:0];
        d = {4'h0, v} << pos[2:0];
        b = (b & ~m) | d;
        w[{pos[5:3], 3'b000} +: 8] = b;
        return w;
    endfunction

    // nibble first, then counter, then crc byte
    function automatic logic [63:0] seal_frame(logic [63:0] f, logic [3:0] ctr);
        logic [63:0] w;
        w = f;
        if (model_cfg.id_mode == ID_NIBBLE)
            w = put_nibble(w, model_cfg.nib_off, model_cfg.data_id[11:8]);
        w = put_nibble(w, model_cfg.cnt_off, ctr);
        w[{model_cfg.crc_idx, 3'b000} +: 8] = frame_crc(w, model_cfg.frame_bytes);
        return w;
    endfunction

    function automatic res_t predict_frame(logic [63:0] f, logic [3:0] len);
        res_t        r;
        logic [63:0] w;
        logic [3:0]  rc;
        int          step;
        r.frame = '0;
        if (len != model_cfg.frame_bytes || len > MAX_FRAME_BYTES)
        begin
            r.status = ST_WRONG_INPUT;
            return r;
        end
        if ((model_cfg.id_mode == ID_NIBBLE && model_cfg.nib_off[5:3] >= len) ||
            model_cfg.cnt_off[5:3] >= len || model_cfg.crc_idx >= len ||
            (model_cfg.role == ROLE_PROTECT && model_cfg.cnt_off[2:0] > 3'd4))
        begin
            r.status = ST_CONFIG_FAULT;
            return r;
        end
        if (model_cfg.role == ROLE_PROTECT)
        begin
            w = seal_frame(f, model_seq);
            for (int i = 0; i < MAX_FRAME_BYTES; i++)
            begin
                if (i < len)
                    r.frame[8*i +: 8] = w[8*i +: 8];
            end
            model_seq = (model_seq == COUNTER_MAX) ? 4'd0 : model_seq + 4'd1;
            r.status  = ST_OK;
        end
        else
        begin
            rc = get_nibble(f, model_cfg.cnt_off);
            if (frame_crc(f, len) != f[{model_cfg.crc_idx, 3'b000} +: 8])
                r.status = ST_ERROR;
            else if (model_cfg.id_mode == ID_NIBBLE &&
                     get_nibble(f, model_cfg.nib_off) != model_cfg.data_id[11:8])
                r.status = ST_ERROR;
            else
            begin
                if (rc >= model_seq)
                    step = int'(rc) - int'(model_seq);
                else
                    step = int'(rc) + COUNTER_MAX + 1 - int'(model_seq);
                model_seq = rc;
                if (step == 0)
                    r.status = ST_REPEATED;
                else if (step == 1)
                    r.status = ST_OK;
                else
                    r.status = ST_LOST;
            end
        end
        return r;
    endfunction

    function automatic cfg_t random_config(role_t r);
        cfg_t c;
        int   pick;
        int   span;
        c.role = r;
        pick = $urandom_range(0, 9);
        c.data_id = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        c.id_mode = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            c.frame_bytes = 4'($urandom_range(0, 15));
        else if (pick < 3)
            c.frame_bytes = 4'd1;
        else if (pick < 5)
            c.frame_bytes = 4'd8;
        else
            c.frame_bytes = 4'($urandom_range(1, 8));
        if ($urandom_range(0, 9) == 0)
        begin
            c.cnt_off = 6'($urandom_range(0, 63));
            c.crc_idx = 3'($urandom_range(0, 7));
            c.nib_off = 6'($urandom_range(0, 63));
        end
        else
        begin
            span = (c.frame_bytes >= 1 && c.frame_bytes <= 8) ? int'(c.frame_bytes) : 8;
            c.cnt_off = 6'($urandom_range(0, 8 * span - 1));
            if (r == ROLE_PROTECT && c.cnt_off[2:0] > 3'd4)
                c.cnt_off[2:0] = 3'($urandom_range(0, 4));
            c.crc_idx = 3'($urandom_range(0, span - 1));
            c.nib_off = 6'($urandom_range(0, 8 * span - 1));
        end
        return c;
    endfunction

    task automatic write_reg(reg_index_t idx, logic [15:0] v);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= v;
        @(posedge clk);
        case (idx)
            REG_ROLE:
            begin
                model_cfg.role = v[0];
                model_seq      = v[0] ? 4'(COUNTER_MAX) : 4'd0;
            end
            REG_DATA_ID:     model_cfg.data_id     = v;
            REG_ID_MODE:     model_cfg.id_mode     = v[1:0];
            REG_FRAME_BYTES: model_cfg.frame_bytes = v[3:0];
            REG_CNT_OFF:     model_cfg.cnt_off     = v[5:0];
            REG_CRC_IDX:     model_cfg.crc_idx     = v[2:0];
            REG_NIB_OFF:     model_cfg.nib_off     = v[5:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(cfg_t c);
        write_reg(REG_ROLE, 16'(c.role));
        write_reg(REG_DATA_ID, c.data_id);
        write_reg(REG_ID_MODE, 16'(c.id_mode));
        write_reg(REG_FRAME_BYTES, 16'(c.frame_bytes));
        write_reg(REG_CNT_OFF, 16'(c.cnt_off));
        write_reg(REG_CRC_IDX, 16'(c.crc_idx));
        write_reg(REG_NIB_OFF, 16'(c.nib_off));
        wr_en <= 1'b0;
        setup_count++;
    endtask

    task automatic send_frame(logic [63:0] f, logic [3:0] len);
        int   gap;
        res_t predicted;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        frame_data <= f;
        frame_len  <= len;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predicted       = predict_frame(f, len);
        pending_results = {pending_results, predicted};
        sent_count++;
    endtask

    task automatic drain_pipeline;
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic test_reset_defaults;
        send_frame(64'h0, 4'd8);
        send_frame({$urandom, $urandom}, 4'd8);
        send_frame({$urandom, $urandom}, 4'd0);
        send_frame({$urandom, $urandom}, 4'd15);
        drain_pipeline;
    endtask

    task automatic test_protect_paths;
        apply_config(make_cfg(ROLE_PROTECT, 16'hFFFF, ID_BOTH, 4'd8, 6'd12, 3'd7, 6'd63));
        send_frame(64'h0, 4'd8);
        send_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        send_frame(64'h0123_4567_89AB_CDEF, 4'd7);
        drain_pipeline;
        // unused id mode behaves like no id
        apply_config(make_cfg(ROLE_PROTECT, 16'h0000, 2'd3, 4'd1, 6'd0, 3'd0, 6'd0));
        send_frame({$urandom, $urandom}, 4'd1);
        drain_pipeline;
        apply_config(make_cfg(ROLE_PROTECT, 16'h0000, ID_NONE, 4'd1, 6'd0, 3'd0, 6'd0));
        send_frame({$urandom, $urandom}, 4'd1);
        drain_pipeline;
    endtask

    task automatic test_nibble_and_faults;
        apply_config(make_cfg(ROLE_PROTECT, 16'h0A5C, ID_NIBBLE, 4'd3, 6'd8, 3'd2, 6'd4));
        send_frame({$urandom, $urandom}, 4'd3);
        send_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd3);
        drain_pipeline;
        apply_config(make_cfg(ROLE_PROTECT, 16'h0A5C, ID_NIBBLE, 4'd3, 6'd8, 3'd2, 6'd24));
        send_frame({$urandom, $urandom}, 4'd3);
        drain_pipeline;
        apply_config(make_cfg(ROLE_PROTECT, 16'h0A5C, ID_BOTH, 4'd3, 6'd13, 3'd2, 6'd0));
        send_frame({$urandom, $urandom}, 4'd3);
        drain_pipeline;
        apply_config(make_cfg(ROLE_PROTECT, 16'h0A5C, ID_BOTH, 4'd3, 6'd8, 3'd3, 6'd0));
        send_frame({$urandom, $urandom}, 4'd3);
        drain_pipeline;
        apply_config(make_cfg(ROLE_PROTECT, 16'h0A5C, ID_BOTH, 4'd0, 6'd0, 3'd0, 6'd0));
        send_frame({$urandom, $urandom}, 4'd0);
        drain_pipeline;
        apply_config(make_cfg(ROLE_PROTECT, 16'h0A5C, ID_BOTH, 4'd9, 6'd0, 3'd0, 6'd0));
        send_frame({$urandom, $urandom}, 4'd9);
        drain_pipeline;
        // nibble spilling past the top of its byte
        apply_config(make_cfg(ROLE_PROTECT, 16'hF9FF, ID_NIBBLE, 4'd8, 6'd4, 3'd0, 6'd62));
        send_frame({$urandom, $urandom}, 4'd8);
        drain_pipeline;
    endtask

    task automatic test_check_status;
        logic [63:0] f;
        apply_config(make_cfg(ROLE_CHECK, 16'h1234, ID_BOTH, 4'd8, 6'd8, 3'd0, 6'd0));
        f = {$urandom, $urandom};
        send_frame(seal_frame(f, 4'd0), 4'd8);
        send_frame(seal_frame(f, 4'd0), 4'd8);
        send_frame(seal_frame(f, 4'd3), 4'd8);
        send_frame(seal_frame(f, 4'd15), 4'd8);
        send_frame(seal_frame(f, 4'd14), 4'd8);
        send_frame(seal_frame(f, 4'd0), 4'd8);
        send_frame(seal_frame(f, 4'd1) ^ 64'h100, 4'd8);
        send_frame(seal_frame(f, 4'd2), 4'd5);
        drain_pipeline;
        // counter spilling past its byte, nibble checked against data id
        apply_config(make_cfg(ROLE_CHECK, 16'hABCD, ID_NIBBLE, 4'd2, 6'd7, 3'd1, 6'd0));
        send_frame(seal_frame(f, 4'd1), 4'd2);
        send_frame(put_nibble(seal_frame(f, 4'd1), 6'd0, 4'h5), 4'd2);
        drain_pipeline;
    endtask

    task automatic run_random_phase(int count);
        logic [63:0] f;
        logic [3:0]  len;
        logic [3:0]  ctr;
        int          pick;
        int          step;
        apply_config(random_config(role_t'($urandom_range(0, 1))));
        ctr = 4'(COUNTER_MAX);
        repeat (count)
        begin
            f    = {$urandom, $urandom};
            len  = model_cfg.frame_bytes;
            pick = $urandom_range(0, 99);
            if (pick < 6)
                len = 4'($urandom_range(0, 15));
            else if (model_cfg.role == ROLE_CHECK)
            begin
                if (pick < 70)
                    ctr = (ctr == COUNTER_MAX) ? 4'd0 : ctr + 4'd1;
                else if (pick < 86 && pick >= 78)
                begin
                    step = $urandom_range(2, 5);
                    ctr  = 4'((int'(ctr) + step) % (COUNTER_MAX + 1));
                end
                else if (pick >= 86 && pick < 89)
                    ctr = 4'hF;
                f = seal_frame(f, ctr);
                if (pick >= 89 && pick < 95 && len != 0)
                    f = f ^ (64'd1 << $urandom_range(0, 8 * len - 1));
                else if (pick >= 95)
                    f = put_nibble(f, model_cfg.nib_off, ~model_cfg.data_id[11:8]);
            end
            send_frame(f, len);
        end
        drain_pipeline;
    endtask

    task automatic test_random_traffic;
        int done;
        int n;
        done = 0;
        while (done < 1800)
        begin
            n = $urandom_range(30, 150);
            run_random_phase(n);
            done += n;
        end
    endtask

    initial
    begin
        res_t want;
        int   stall;
        @(posedge rst_n);
        forever
        begin
            stall = rx_burst ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                errors++;
                $error("result with no request pending: frame_out %h status %0d",
                       frame_out, status);
            end
            else
            begin
                want = pending_results.pop_front();
                status_hits[want.status]++;
                if (frame_out !== want.frame)
                begin
                    errors++;
                    $error("frame_out expected %h got %h", want.frame, frame_out);
                end
                if (status !== want.status)
                begin
                    errors++;
                    $error("status expected %0d got %0d", want.status, status);
                end
            end
        end
    end

    initial
    begin
        model_cfg = make_cfg(ROLE_PROTECT, 16'h0000, ID_BOTH, 4'd8, 6'd0, 3'd0, 6'd0);
        model_seq = 4'd0;
        foreach (status_hits[i])
            status_hits[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults;
        test_protect_paths;
        test_nibble_and_faults;
        test_check_status;
        test_random_traffic;
        $display("sent %0d frames under %0d register setups in both roles",
                 sent_count, setup_count);
        $display("status mix: ok %0d, lost %0d, repeated %0d, error %0d, wrong input %0d, %s %0d",
                 status_hits[ST_OK], status_hits[ST_LOST], status_hits[ST_REPEATED],
                 status_hits[ST_ERROR], status_hits[ST_WRONG_INPUT], "config fault",
                 status_hits[ST_CONFIG_FAULT]);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
